>>> design/ptlg_pkg.sv
package ptlg_pkg;

   // field widths
   localparam int FREQ_W   = 16;
   localparam int PWR_W    = 24;
   localparam int LOAD_W   = 8;
   localparam int STATUS_W = 3;
   localparam int OP_W     = 2;
   // index carried by a chain token, wide enough for the deepest table
   localparam int IDX_W    = 6;

   // governor thresholds
   localparam int LOAD_HIGH = 80;
   localparam int LOAD_LOW  = 20;
   localparam int LOAD_MAX  = 100;
   // divide by the load span (60) as multiply by ceil(2^20/60) and shift
   localparam int RECIP_W     = 15;
   localparam int RECIP       = 17477;
   localparam int RECIP_SHIFT = 20;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 2'd0,
      OP_GOV  = 2'd1,
      OP_SET  = 2'd2,
      OP_RSVD = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_ZERO_FREQ  = 3'd1,
      ST_FULL       = 3'd2,
      ST_EMPTY      = 3'd3,
      ST_NOT_LISTED = 3'd4
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic [FREQ_W-1:0]        frequency_mhz;
      logic [PWR_W-1:0]         power_mw;
      logic signed [LOAD_W-1:0] load_percent;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FREQ_W-1:0]   chosen_mhz;
      logic [FREQ_W-1:0]   current_mhz;
   } rsp_type;

   // token handed from cell to cell; freq/power is the carried entry
   typedef struct packed {
      logic              live;
      opcode_type        op;
      logic [FREQ_W-1:0] freq;
      logic [PWR_W-1:0]  power;
      logic [IDX_W-1:0]  idx;
      logic              found;
      logic              placed;
      logic [FREQ_W-1:0] chosen;
   } chain_type;

endpackage

>>> design/ptlg_cell.sv
module ptlg_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CNT_W-1:0]     count,
   input  ptlg_pkg::chain_type  tok_in,
   output ptlg_pkg::chain_type  tok_out
);

   logic [ptlg_pkg::FREQ_W-1:0] freq_ff, freq_in;
   logic [ptlg_pkg::PWR_W-1:0]  pwr_ff, pwr_in;
   ptlg_pkg::chain_type         tok_ff, tok_in_nx;
   logic                        used;
   logic                        first_free;

   assign used       = CNT_W'(CELL_INDEX) < count;
   assign first_free = CNT_W'(CELL_INDEX) == count;

   // act on the token passing through this cell
   always_comb begin
      freq_in   = freq_ff;
      pwr_in    = pwr_ff;
      tok_in_nx = tok_in;
      if (tok_in.live) begin
         case (tok_in.op)
            ptlg_pkg::OP_ADD: begin
               if (used && !tok_in.found) begin
                  if (!tok_in.placed && freq_ff == tok_in.freq) begin
                     // update power of a listed frequency
                     pwr_in          = tok_in.power;
                     tok_in_nx.found = 1'b1;
                  end else if (tok_in.placed || freq_ff > tok_in.freq) begin
                     // swap: keep the carried entry, hand ours down
                     freq_in          = tok_in.freq;
                     pwr_in           = tok_in.power;
                     tok_in_nx.freq   = freq_ff;
                     tok_in_nx.power  = pwr_ff;
                     tok_in_nx.placed = 1'b1;
                  end
               end else if (first_free && !tok_in.found) begin
                  // append the carried entry at the end of the table
                  freq_in          = tok_in.freq;
                  pwr_in           = tok_in.power;
                  tok_in_nx.placed = 1'b1;
               end
            end
            ptlg_pkg::OP_GOV: begin
               if (used && tok_in.idx == ptlg_pkg::IDX_W'(CELL_INDEX)) begin
                  tok_in_nx.chosen = freq_ff;
               end
            end
            ptlg_pkg::OP_SET: begin
               if (used && freq_ff == tok_in.freq) begin
                  tok_in_nx.found = 1'b1;
               end
            end
            default: begin
               tok_in_nx = tok_in;
            end
         endcase
      end
   end

   // hold the entry
   always_ff @(posedge clock) begin
      freq_ff <= freq_in;
      pwr_ff  <= pwr_in;
   end

   // advance the token one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nx;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> design/ptlg_gov_index.sv
module ptlg_gov_index #(
   parameter int CNT_W = 5
) (
   input  logic                                clock,
   input  logic signed [ptlg_pkg::LOAD_W-1:0] load,
   input  logic [CNT_W-1:0]                    count,
   output logic [ptlg_pkg::IDX_W-1:0]          idx
);

   // load minus the low threshold stays below 60 in the middle band
   localparam int DIFF_W = 6;
   localparam int PROD_W = DIFF_W + CNT_W;
   localparam int Q_W    = PROD_W + ptlg_pkg::RECIP_W;

   logic [6:0]                  ld;
   logic [DIFF_W-1:0]           diff;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic                        hi_ff, hi_in, lo_ff, lo_in;
   logic [Q_W-1:0]              q_full;
   logic [CNT_W-1:0]            q, cnt_m1, pick;
   logic [ptlg_pkg::IDX_W-1:0]  idx_ff;

   // clamp the load and form (load - 20) * count
   always_comb begin
      if (load < 8'sd0) begin
         ld = 7'd0;
      end else if (load > 8'(ptlg_pkg::LOAD_MAX)) begin
         ld = 7'(ptlg_pkg::LOAD_MAX);
      end else begin
         ld = 7'(load);
      end
      hi_in   = ld >= 7'(ptlg_pkg::LOAD_HIGH);
      lo_in   = ld <= 7'(ptlg_pkg::LOAD_LOW);
      diff    = DIFF_W'(ld - 7'(ptlg_pkg::LOAD_LOW));
      prod_in = PROD_W'(diff) * PROD_W'(count);
   end

   // divide by the span and cap at the last entry; high load picks the last entry, low load the first
   always_comb begin
      q_full = Q_W'(prod_ff) * Q_W'(ptlg_pkg::RECIP);
      q      = CNT_W'(q_full >> ptlg_pkg::RECIP_SHIFT);
      cnt_m1 = count - CNT_W'(1);
      if (hi_ff) begin
         pick = cnt_m1;
      end else if (lo_ff) begin
         pick = '0;
      end else if (q > cnt_m1) begin
         pick = cnt_m1;
      end else begin
         pick = q;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      idx_ff  <= ptlg_pkg::IDX_W'(pick);
   end

   assign idx = idx_ff;

endmodule

>>> design/pstate_table_load_governor.sv
// An add, governor or set request sends a token along the row of table cells, one cell per
// cycle, and gives its result once the token leaves the last cell; a rejected or ignored
// request is answered without a walk. A new request is taken only after the result of the
// last one has gone out; a result waits in the done state while an earlier one is stalled.
// Reset (synchronous): empties the table, clears the current frequency and drops any
// pending result; table entries keep stale contents that are never read.
module pstate_table_load_governor #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ptlg_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ptlg_pkg::rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_LAUNCH,
      S_RUN,
      S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   ptlg_pkg::req_type           req_ff, req_in;
   ptlg_pkg::chain_type         fin_ff, fin_in;
   ptlg_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [ptlg_pkg::FREQ_W-1:0] current_ff, current_in;
   ptlg_pkg::chain_type         tok [TABLE_DEPTH+1];
   logic [TABLE_DEPTH:0]        chain_live;
   logic [ptlg_pkg::IDX_W-1:0]  gov_idx;
   logic                        req_acc;
   logic                        skip;
   ptlg_pkg::status_type        skip_status;
   ptlg_pkg::status_type        st;

   assign req_stall = state_ff != S_IDLE;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // index pick for the governor, fed straight from the port
   ptlg_gov_index #(
      .CNT_W (CNT_W)
   ) u_gov (
      .clock (clock),
      .load  (req_data.load_percent),
      .count (count_ff),
      .idx   (gov_idx)
   );

   // launch token into the first cell
   always_comb begin
      tok[0]        = '0;
      tok[0].live   = state_ff == S_LAUNCH;
      tok[0].op     = ptlg_pkg::opcode_type'(req_ff.opcode);
      tok[0].freq   = req_ff.frequency_mhz;
      tok[0].power  = req_ff.power_mw;
      tok[0].idx    = gov_idx;
   end

   // row of table cells, one entry each
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ptlg_cell #(
         .CELL_INDEX (i),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count   (count_ff),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   for (genvar i = 0; i <= TABLE_DEPTH; i++) begin : g_live
      assign chain_live[i] = tok[i].live;
   end

   // requests answered without a walk
   always_comb begin
      skip        = 1'b0;
      skip_status = ptlg_pkg::ST_OK;
      case (ptlg_pkg::opcode_type'(req_ff.opcode))
         ptlg_pkg::OP_ADD: begin
            if (req_ff.frequency_mhz == '0) begin
               skip        = 1'b1;
               skip_status = ptlg_pkg::ST_ZERO_FREQ;
            end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
               skip        = 1'b1;
               skip_status = ptlg_pkg::ST_FULL;
            end
         end
         ptlg_pkg::OP_GOV: begin
            if (count_ff == '0) begin
               skip        = 1'b1;
               skip_status = ptlg_pkg::ST_EMPTY;
            end
         end
         ptlg_pkg::OP_SET: begin
            skip = 1'b0;
         end
         default: begin
            skip = 1'b1;
         end
      endcase
   end

   // sequence one request at a time
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      fin_in       = fin_ff;
      count_in     = count_ff;
      current_in   = current_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      st           = ptlg_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               req_in   = req_data;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            state_in = skip ? S_DONE : S_LAUNCH;
         end
         S_LAUNCH: begin
            state_in = S_RUN;
         end
         S_RUN: begin
            if (tok[TABLE_DEPTH].live) begin
               fin_in   = tok[TABLE_DEPTH];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.chosen_mhz = '0;
               if (skip) begin
                  st = skip_status;
               end else begin
                  case (ptlg_pkg::opcode_type'(req_ff.opcode))
                     ptlg_pkg::OP_ADD: begin
                        if (!fin_ff.found) begin
                           count_in = count_ff + CNT_W'(1);
                           if (current_ff == '0) begin
                              current_in = req_ff.frequency_mhz;
                           end
                        end
                     end
                     ptlg_pkg::OP_GOV: begin
                        rsp_in.chosen_mhz = fin_ff.chosen;
                     end
                     ptlg_pkg::OP_SET: begin
                        if (fin_ff.found) begin
                           current_in = req_ff.frequency_mhz;
                        end else begin
                           st = ptlg_pkg::ST_NOT_LISTED;
                        end
                     end
                     default: begin
                        st = ptlg_pkg::ST_OK;
                     end
                  endcase
               end
               rsp_in.status      = st;
               rsp_in.current_mhz = current_in;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      fin_ff <= fin_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // table never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // at most one token walks the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_live) <= 1)
      else $error("more than one token in the cell row");

   // count only grows by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("entry count changed by more than one");

   // a result appears only on leaving the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

   // a table with any entries always has a current frequency
   a_current_set: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> current_ff != '0)
      else $error("current frequency zero with entries listed");

endmodule
